/* hdl/sks_pkg.sv */
// ----------------------------------------------------------------------------
// sks_pkg
// Types and constants shared by the servo key striker blocks.
// ----------------------------------------------------------------------------
package sks_pkg;

    // item modes
    localparam logic [1:0] MODE_STRIKE = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_LOAD   = 2'd2;

    localparam int KEY_W   = 5;
    localparam int CHAN_W  = 4;
    localparam int VEL_W   = 7;
    localparam int ANG_W   = 8;
    localparam int PULSE_W = 12;
    localparam int TICK_W  = 16;

    localparam logic [TICK_W-1:0] RELEASE_TICKS_RST = 16'd100;
    localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;

    // velocity full scale
    localparam logic signed [8:0] VEL_SCALE = 9'sd127;

    // shared divider: signed dividend and divisor, three quotient bits a cycle
    localparam int DVD_W    = 22;
    localparam int DVS_W    = 9;
    localparam int DMAG_W   = DVD_W - 1;
    localparam int SMAG_W   = DVS_W - 1;
    localparam int DIV_BITS = 3;
    localparam int DIV_ITER = DMAG_W / DIV_BITS;
    localparam int DCNT_W   = $clog2(DIV_ITER + 1);

    // angle arithmetic width, holds angle + offset - min_angle
    localparam int AX_W = 12;
    localparam int PD_W = PULSE_W + 1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [KEY_W-1:0]   key;
        logic [VEL_W-1:0]   velocity;
        logic [ANG_W-1:0]   min_angle;
        logic [ANG_W-1:0]   max_angle;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic signed [ANG_W-1:0] angle_offset;
        logic [ANG_W-1:0]   soft_angle;
        logic [ANG_W-1:0]   hard_angle;
        logic [ANG_W-1:0]   rest_angle;
    } t_item;

    typedef struct packed {
        logic [ANG_W-1:0]   min_angle;
        logic [ANG_W-1:0]   max_angle;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [ANG_W-1:0]   offset;
        logic [ANG_W-1:0]   soft_angle;
        logic [ANG_W-1:0]   hard_angle;
        logic [ANG_W-1:0]   rest_angle;
    } t_cal;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [PULSE_W-1:0] pulse_us;
        logic               is_release;
        logic               last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic cal_wr;
        logic tick_start;
        logic scan_inc;
        logic mul_vel;
        logic div_start;
        logic div_pulse;
        logic ang_set;
        logic mul_pulse;
        logic clamp;
        logic emit;
        logic arm;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       strike_ok;
        logic       load_ok;
        logic       div_busy;
        logic       div_done;
        logic       out_free;
        logic       scan_hit;
        logic       mask_empty;
    } t_sts;

endpackage

/* hdl/sks_if.sv */
// ----------------------------------------------------------------------------
// sks_if
// Valid/ready channels for striker items and pulse results.
// ----------------------------------------------------------------------------
interface sks_item_if import sks_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [KEY_W-1:0]        key;
    logic [VEL_W-1:0]        velocity;
    logic [ANG_W-1:0]        min_angle;
    logic [ANG_W-1:0]        max_angle;
    logic [PULSE_W-1:0]      min_pulse;
    logic [PULSE_W-1:0]      max_pulse;
    logic signed [ANG_W-1:0] angle_offset;
    logic [ANG_W-1:0]        soft_angle;
    logic [ANG_W-1:0]        hard_angle;
    logic [ANG_W-1:0]        rest_angle;

    modport source (
        output valid, mode, key, velocity, min_angle, max_angle, min_pulse, max_pulse,
               angle_offset, soft_angle, hard_angle, rest_angle,
        input  ready
    );
    modport sink (
        input  valid, mode, key, velocity, min_angle, max_angle, min_pulse, max_pulse,
               angle_offset, soft_angle, hard_angle, rest_angle,
        output ready
    );
endinterface

interface sks_res_if import sks_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  channel;
    logic [PULSE_W-1:0] pulse_us;
    logic               is_release;
    logic               last;

    modport source (
        output valid, channel, pulse_us, is_release, last,
        input  ready
    );
    modport sink (
        input  valid, channel, pulse_us, is_release, last,
        output ready
    );
endinterface

/* hdl/sks_divider.sv */
// ----------------------------------------------------------------------------
// sks_divider
// Iterative signed divider, restoring, three quotient bits per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module sks_divider import sks_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic signed [DVS_W-1:0] i_divisor,
    output logic                    o_busy,
    output logic                    o_done,
    output logic signed [DVD_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_neg;
    logic [SMAG_W-1:0] r_dvs;
    logic [SMAG_W-1:0] r_rem;
    logic [DMAG_W-1:0] r_q;
    logic [SMAG_W-1:0] n_rem;
    logic [DMAG_W-1:0] n_q;
    logic [SMAG_W:0]   trial;
    logic [DVD_W-1:0]  dvd_abs;
    logic [DVS_W-1:0]  dvs_abs;

    assign dvd_abs = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
    assign dvs_abs = i_divisor[DVS_W-1] ? DVS_W'(-i_divisor) : DVS_W'(i_divisor);

    always_comb begin
        n_rem = r_rem;
        n_q   = r_q;
        trial = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {n_rem, n_q[DMAG_W-1]};
            n_q   = {n_q[DMAG_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                trial  = trial - {1'b0, r_dvs};
                n_q[0] = 1'b1;
            end
            n_rem = trial[SMAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DVD_W-1] ^ i_divisor[DVS_W-1];
            r_q   <= dvd_abs[DMAG_W-1:0];
            r_dvs <= dvs_abs[SMAG_W-1:0];
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

/* hdl/sks_datapath.sv */
// ----------------------------------------------------------------------------
// sks_datapath
// Calibration memory, release countdowns, angle and pulse arithmetic,
// result register.
// ----------------------------------------------------------------------------
module sks_datapath import sks_pkg::*; #(
    parameter int KEYS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TICK_W-1:0] i_cfg_wr_data,
    input  t_item             i_item,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_res              o_out
);

    localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [KEY_W-1:0] KEYS_K = KEY_W'(KEYS);

    t_item              r_item;
    logic [TICK_W-1:0]  r_release_ticks;
    t_cal               r_cal_mem [KEYS];
    t_cal               r_cal;
    logic [TICK_W-1:0]  r_rem [KEYS];
    logic [KEYS-1:0]    r_mask;
    logic [KEYS-1:0]    n_mask;
    logic [IDX_W-1:0]   r_scan_idx;
    logic signed [DVD_W-1:0] r_prod;
    logic signed [AX_W-1:0]  r_xd;
    logic signed [PD_W-1:0]  r_pd;
    logic               r_eq;
    logic [PULSE_W-1:0] r_pulse;
    logic               r_out_valid;
    t_res               r_out;

    logic               is_tick;
    logic [IDX_W-1:0]   strike_idx;
    logic [IDX_W-1:0]   load_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic               key_in_range;
    logic [TICK_W-1:0]  arm_cnt;
    logic               out_free;
    logic               rel_last;
    logic signed [8:0]  vdiff;
    logic signed [16:0] vprod;
    logic signed [24:0] pprod;
    logic signed [DVS_W-1:0] divisor;
    logic [AX_W-1:0]    ang;
    logic [AX_W-1:0]    xd;
    logic signed [DVD_W-1:0] quot;
    logic               div_busy;
    logic               div_done;
    logic signed [DVD_W:0] p_raw;
    logic signed [DVD_W:0] p_min;
    logic signed [DVD_W:0] p_max;
    logic [PULSE_W-1:0] p_clamped;

    assign is_tick      = (r_item.mode == MODE_TICK);
    assign strike_idx   = IDX_W'(r_item.key - KEY_W'(1));
    assign load_idx     = IDX_W'(r_item.key);
    assign rd_idx       = is_tick ? r_scan_idx : strike_idx;
    assign key_in_range = (r_item.key != '0) && (r_item.key <= KEYS_K);
    assign arm_cnt      = (r_release_ticks == TICK_MAX) ? TICK_MAX
                                                        : r_release_ticks + TICK_W'(1);
    assign out_free     = !r_out_valid || i_out_ready;
    assign rel_last     = (r_mask & ~(KEYS'(1) << r_scan_idx)) == '0;

    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            n_mask[k] = (r_rem[k] == TICK_W'(1));
        end
    end

    // arithmetic
    assign vdiff   = $signed({1'b0, r_cal.hard_angle}) - $signed({1'b0, r_cal.soft_angle});
    assign vprod   = $signed({1'b0, r_item.velocity}) * vdiff;
    assign pprod   = r_xd * r_pd;
    assign divisor = i_cmd.div_pulse
                   ? $signed({1'b0, r_cal.max_angle}) - $signed({1'b0, r_cal.min_angle})
                   : VEL_SCALE;
    // strike angle from the quotient, release angle straight from the table
    assign ang = is_tick ? {4'b0, r_cal.rest_angle}
                         : quot[AX_W-1:0] + {4'b0, r_cal.soft_angle};
    assign xd  = ang + {{4{r_cal.offset[ANG_W-1]}}, r_cal.offset} - {4'b0, r_cal.min_angle};

    assign p_min = $signed({11'b0, r_cal.min_pulse});
    assign p_max = $signed({11'b0, r_cal.max_pulse});

    always_comb begin
        p_raw = r_eq ? p_min : $signed({quot[DVD_W-1], quot}) + p_min;
        if (p_raw < p_min) begin
            p_raw = p_min;
        end
        if (p_raw > p_max) begin
            p_raw = p_max;
        end
        p_clamped = p_raw[PULSE_W-1:0];
    end

    sks_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // calibration memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.cal_wr) begin
            r_cal_mem[load_idx] <= '{min_angle:  r_item.min_angle,
                                     max_angle:  r_item.max_angle,
                                     min_pulse:  r_item.min_pulse,
                                     max_pulse:  r_item.max_pulse,
                                     offset:     r_item.angle_offset,
                                     soft_angle: r_item.soft_angle,
                                     hard_angle: r_item.hard_angle,
                                     rest_angle: r_item.rest_angle};
        end
        r_cal <= r_cal_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_ticks <= RELEASE_TICKS_RST;
            r_mask          <= '0;
            r_scan_idx      <= '0;
            r_out_valid     <= 1'b0;
            for (int k = 0; k < KEYS; k++) begin
                r_rem[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_release_ticks <= i_cfg_wr_data;
            end
            if (i_cmd.tick_start) begin
                for (int k = 0; k < KEYS; k++) begin
                    if (r_rem[k] != '0) begin
                        r_rem[k] <= r_rem[k] - TICK_W'(1);
                    end
                end
            end else if (i_cmd.arm) begin
                r_rem[strike_idx] <= arm_cnt;
            end
            if (i_cmd.tick_start) begin
                r_mask     <= n_mask;
                r_scan_idx <= '0;
            end else begin
                if (i_cmd.scan_inc) begin
                    r_scan_idx <= r_scan_idx + IDX_W'(1);
                end
                if (i_cmd.emit && is_tick) begin
                    r_mask[r_scan_idx] <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.mul_vel) begin
            r_prod <= {{(DVD_W-17){vprod[16]}}, vprod};
        end else if (i_cmd.mul_pulse) begin
            r_prod <= pprod[DVD_W-1:0];
        end
        if (i_cmd.ang_set) begin
            r_xd <= $signed(xd);
            r_pd <= $signed({1'b0, r_cal.max_pulse}) - $signed({1'b0, r_cal.min_pulse});
            r_eq <= (r_cal.max_angle == r_cal.min_angle);
        end
        if (i_cmd.clamp) begin
            r_pulse <= p_clamped;
        end
        if (i_cmd.emit) begin
            r_out.channel    <= CHAN_W'(rd_idx);
            r_out.pulse_us   <= r_pulse;
            r_out.is_release <= is_tick;
            r_out.last       <= is_tick ? rel_last : 1'b1;
        end
    end

    assign o_sts.mode       = r_item.mode;
    assign o_sts.strike_ok  = key_in_range && (r_rem[strike_idx] == '0);
    assign o_sts.load_ok    = (r_item.key < KEYS_K);
    assign o_sts.div_busy   = div_busy;
    assign o_sts.div_done   = div_done;
    assign o_sts.out_free   = out_free;
    assign o_sts.scan_hit   = r_mask[r_scan_idx];
    assign o_sts.mask_empty = (r_mask == '0);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hdl/sks_ctrl.sv */
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer for strike, tick scan and calibration load.
// ----------------------------------------------------------------------------
module sks_ctrl import sks_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_VMUL   = 4'd2;
    localparam logic [3:0] S_VSTART = 4'd3;
    localparam logic [3:0] S_VWAIT  = 4'd4;
    localparam logic [3:0] S_ANGLE  = 4'd5;
    localparam logic [3:0] S_PMUL   = 4'd6;
    localparam logic [3:0] S_PSTART = 4'd7;
    localparam logic [3:0] S_PWAIT  = 4'd8;
    localparam logic [3:0] S_CLAMP  = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;
    localparam logic [3:0] S_SCAN   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.mode)
                    MODE_STRIKE: begin
                        n_state = i_sts.strike_ok ? S_VMUL : S_IDLE;
                    end
                    MODE_TICK: begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    MODE_LOAD: begin
                        o_cmd.cal_wr = i_sts.load_ok;
                        n_state      = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_VMUL: begin
                o_cmd.mul_vel = 1'b1;
                n_state       = S_VSTART;
            end
            S_VSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_VWAIT;
            end
            S_VWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd.ang_set = 1'b1;
                n_state       = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.mul_pulse = 1'b1;
                n_state         = S_PSTART;
            end
            S_PSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_pulse = 1'b1;
                n_state         = S_PWAIT;
            end
            S_PWAIT: begin
                o_cmd.div_pulse = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.mode == MODE_STRIKE) begin
                        o_cmd.arm = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // walk the expiry mask, one key a cycle until an expiring key is found and sent
                if (i_sts.mask_empty) begin
                    n_state = S_IDLE;
                end else if (i_sts.scan_hit) begin
                    n_state = S_ANGLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/servo_key_striker_with_release_timer.sv */
// A strike on an idle key goes through decode, velocity multiply, first division, angle,
//   pulse multiply, second division, clamp and emit into the result register, where emit
//   waits for a free output register; loads and ignored items end after decode.
// A new item is only accepted in idle, once the previous one is done; a tick scans the
//   expiry mask and runs angle through emit for each expiring key.
// Synchronous active-low reset idles all keys, sets release_ticks to 100, keeps calibration.
// ----------------------------------------------------------------------------
// servo_key_striker_with_release_timer
// Multi-key servo striker: calibration load, velocity strikes, timed release.
// ----------------------------------------------------------------------------
module servo_key_striker_with_release_timer import sks_pkg::*; #(
    parameter int KEYS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TICK_W-1:0] i_cfg_wr_data,
    sks_item_if.sink          i_item,
    sks_res_if.source         o_res
);

    t_item item;
    t_cmd  cmd;
    t_sts  sts;
    t_res  res;
    logic  res_valid;

    assign item.mode         = i_item.mode;
    assign item.key          = i_item.key;
    assign item.velocity     = i_item.velocity;
    assign item.min_angle    = i_item.min_angle;
    assign item.max_angle    = i_item.max_angle;
    assign item.min_pulse    = i_item.min_pulse;
    assign item.max_pulse    = i_item.max_pulse;
    assign item.angle_offset = i_item.angle_offset;
    assign item.soft_angle   = i_item.soft_angle;
    assign item.hard_angle   = i_item.hard_angle;
    assign item.rest_angle   = i_item.rest_angle;

    sks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sks_datapath #(
        .KEYS (KEYS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (item),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (res_valid),
        .o_out         (res)
    );

    assign o_res.valid      = res_valid;
    assign o_res.channel    = res.channel;
    assign o_res.pulse_us   = res.pulse_us;
    assign o_res.is_release = res.is_release;
    assign o_res.last       = res.last;

    // a result is only loaded into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded while output register occupied");

    // the divider is never restarted mid-division
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // arming only goes with a strike result
    a_arm_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.arm |-> (cmd.emit && sts.mode == MODE_STRIKE))
        else $error("countdown armed without strike result");

    // ready drops after an item is accepted, so items are never taken back to back
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("item accepted back to back");

endmodule

/* verif/tb_servo_key_striker_with_release_timer.sv */
// ----------------------------------------------------------------------------
// tb_servo_key_striker_with_release_timer
// Self-checking bench for the servo key striker. Calibration loads, strikes
// and ticks go in with random idle on both channels; every pulse command is
// checked against a local prediction of the key timers and calibration.
// ----------------------------------------------------------------------------
module tb_servo_key_striker_with_release_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import sks_pkg::*;

    localparam int NUM_KEYS      = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int TIMEOUT_NS    = 20_000_000;

    // mode code the block does not use
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // prediction of key timers and pulse commands
    // ------------------------------------------------------------------------
    class pulse_tracker;
        t_cal              cal[NUM_KEYS];
        logic [TICK_W-1:0] countdown[NUM_KEYS];
        logic [TICK_W-1:0] release_ticks;
        t_res              pending_pulses[$];
        int                errors;

        function new();
            release_ticks = RELEASE_TICKS_RST;
            foreach (countdown[k]) countdown[k] = '0;
            errors = 0;
        endfunction

        function void set_release_ticks(input logic [TICK_W-1:0] value);
            release_ticks = value;
        endfunction

        // angle plus offset onto the pulse range, clamped low first, then high
        function logic [PULSE_W-1:0] pulse_for(input int angle, input int k);
            int x, amin, amax, pmin, pmax, p;
            x    = angle + int'($signed(cal[k].offset));
            amin = int'(cal[k].min_angle);
            amax = int'(cal[k].max_angle);
            pmin = int'(cal[k].min_pulse);
            pmax = int'(cal[k].max_pulse);
            if (amax == amin) begin
                p = pmin;
            end else begin
                p = (x - amin) * (pmax - pmin) / (amax - amin) + pmin;
            end
            if (p < pmin) p = pmin;
            if (p > pmax) p = pmax;
            return PULSE_W'(p);
        endfunction

        function void apply_item(input t_item it);
            int   k, soft_ang, hard_ang, angle, cnt, before_tick;
            t_res r;
            case (it.mode)
                MODE_STRIKE: begin
                    k = int'(it.key) - 1;
                    if (k >= 0 && k < NUM_KEYS && countdown[k] == 0) begin
                        soft_ang = int'(cal[k].soft_angle);
                        hard_ang = int'(cal[k].hard_angle);
                        angle    = int'(it.velocity) * (hard_ang - soft_ang) / int'(VEL_SCALE)
                                   + soft_ang;
                        r = '{channel: CHAN_W'(k), pulse_us: pulse_for(angle, k),
                              is_release: 1'b0, last: 1'b1};
                        pending_pulses.push_back(r);
                        cnt = int'(release_ticks) + 1;
                        if (cnt > int'(TICK_MAX)) cnt = int'(TICK_MAX);
                        countdown[k] = TICK_W'(cnt);
                    end
                end
                MODE_TICK: begin
                    before_tick = pending_pulses.size();
                    for (k = 0; k < NUM_KEYS; k++) begin
                        if (countdown[k] != 0) begin
                            countdown[k] = countdown[k] - 1'b1;
                            if (countdown[k] == 0) begin
                                r = '{channel: CHAN_W'(k),
                                      pulse_us: pulse_for(int'(cal[k].rest_angle), k),
                                      is_release: 1'b1, last: 1'b0};
                                pending_pulses.push_back(r);
                            end
                        end
                    end
                    if (pending_pulses.size() > before_tick) begin
                        r = pending_pulses.pop_back();
                        r.last = 1'b1;
                        pending_pulses.push_back(r);
                    end
                end
                MODE_LOAD: begin
                    if (int'(it.key) < NUM_KEYS) begin
                        cal[it.key] = '{min_angle: it.min_angle, max_angle: it.max_angle,
                                        min_pulse: it.min_pulse, max_pulse: it.max_pulse,
                                        offset: it.angle_offset, soft_angle: it.soft_angle,
                                        hard_angle: it.hard_angle, rest_angle: it.rest_angle};
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_pulse(input t_res got);
            t_res want;
            if (pending_pulses.size() == 0) begin
                $error("unexpected pulse command: channel %0d pulse_us %0d",
                       got.channel, got.pulse_us);
                errors++;
            end else begin
                want = pending_pulses.pop_front();
                if (got.channel !== want.channel) begin
                    $error("channel: expected %0d, actual %0d", want.channel, got.channel);
                    errors++;
                end
                if (got.pulse_us !== want.pulse_us) begin
                    $error("pulse_us: expected %0d, actual %0d", want.pulse_us, got.pulse_us);
                    errors++;
                end
                if (got.is_release !== want.is_release) begin
                    $error("is_release: expected %0b, actual %0b",
                           want.is_release, got.is_release);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, got.last);
                    errors++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TICK_W-1:0] cfg_wr_data;

    bit in_idle         = 1'b1;
    bit out_idle        = 1'b1;
    int hold_off_cycles = 0;

    pulse_tracker tracker = new();

    sks_item_if item_if ();
    sks_res_if  res_if ();

    always #10 clk = ~clk;

    servo_key_striker_with_release_timer #(
        .KEYS(NUM_KEYS)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_item       (item_if),
        .o_res        (res_if)
    );

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic t_item random_fill();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[$bits(t_item)-1:0];
    endfunction

    function automatic t_item cal_item(input int key, amin, amax, pmin, pmax, offset,
                                       soft_ang, hard_ang, rest);
        t_item it;
        it              = random_fill();
        it.mode         = MODE_LOAD;
        it.key          = KEY_W'(key);
        it.min_angle    = ANG_W'(amin);
        it.max_angle    = ANG_W'(amax);
        it.min_pulse    = PULSE_W'(pmin);
        it.max_pulse    = PULSE_W'(pmax);
        it.angle_offset = ANG_W'(offset);
        it.soft_angle   = ANG_W'(soft_ang);
        it.hard_angle   = ANG_W'(hard_ang);
        it.rest_angle   = ANG_W'(rest);
        return it;
    endfunction

    function automatic t_item strike_item(input int key, input int vel);
        t_item it;
        it          = random_fill();
        it.mode     = MODE_STRIKE;
        it.key      = KEY_W'(key);
        it.velocity = VEL_W'(vel);
        return it;
    endfunction

    function automatic t_item tick_item();
        t_item it;
        it      = random_fill();
        it.mode = MODE_TICK;
        return it;
    endfunction

    function automatic int random_velocity();
        if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 127 : 0;
        return $urandom_range(0, 127);
    endfunction

    // now and then beyond the usual 0..180 degrees
    function automatic int random_angle(input bit wide);
        return wide ? $urandom_range(0, 255) : $urandom_range(0, 180);
    endfunction

    function automatic t_item random_cal(input int key);
        bit wide, crossed;
        int amin, amax, plo, phi, swap, offset;
        wide    = ($urandom_range(0, 7) == 0);
        crossed = ($urandom_range(0, 7) == 0);
        amin    = random_angle(wide);
        amax    = ($urandom_range(0, 7) == 0) ? amin : random_angle(wide);
        plo     = $urandom_range(0, 4095);
        phi     = $urandom_range(0, 4095);
        // pulse limits mostly in order, sometimes crossed
        if ((plo > phi) != crossed) begin
            swap = plo;
            plo  = phi;
            phi  = swap;
        end
        offset = wide ? $urandom_range(0, 255) : int'($urandom_range(0, 180)) - 90;
        return cal_item(key, amin, amax, plo, phi, offset, random_angle(wide),
                        random_angle(wide), random_angle(wide));
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic present(input t_item it);
        item_if.mode         <= it.mode;
        item_if.key          <= it.key;
        item_if.velocity     <= it.velocity;
        item_if.min_angle    <= it.min_angle;
        item_if.max_angle    <= it.max_angle;
        item_if.min_pulse    <= it.min_pulse;
        item_if.max_pulse    <= it.max_pulse;
        item_if.angle_offset <= it.angle_offset;
        item_if.soft_angle   <= it.soft_angle;
        item_if.hard_angle   <= it.hard_angle;
        item_if.rest_angle   <= it.rest_angle;
    endtask

    task automatic send_item(input t_item it);
        int gap;
        gap = in_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        present(it);
        item_if.valid <= 1'b1;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        tracker.apply_item(it);
    endtask

    // loads, ignored items and quiet ticks give no result, so allow them to finish too
    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (tracker.pending_pulses.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_release_ticks(input logic [TICK_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_release_ticks(value);
    endtask

    task automatic run_random(input int count, input int strike_pct, input int tick_pct);
        int    pick, k;
        int    idle_keys[$];
        t_item it;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < strike_pct) begin
                idle_keys = {};
                for (k = 0; k < NUM_KEYS; k++) begin
                    if (tracker.countdown[k] == 0) idle_keys.push_back(k);
                end
                // mostly idle keys, some strikes on busy ones
                if (idle_keys.size() != 0 && $urandom_range(0, 4) != 0) begin
                    k = idle_keys[$urandom_range(0, idle_keys.size() - 1)];
                end else begin
                    k = $urandom_range(0, NUM_KEYS - 1);
                end
                it = strike_item(k + 1, random_velocity());
            end else if (pick < strike_pct + tick_pct) begin
                it = tick_item();
            end else if (pick < 95) begin
                it = random_cal($urandom_range(0, NUM_KEYS - 1));
            end else begin
                it = random_fill();
                case ($urandom_range(0, 2))
                    0: it.mode = MODE_UNUSED;
                    1: begin
                        it.mode = MODE_STRIKE;
                        it.key  = $urandom_range(0, 1) ? KEY_W'(0)
                                                       : KEY_W'($urandom_range(NUM_KEYS + 1, 31));
                    end
                    default: begin
                        it.mode = MODE_LOAD;
                        it.key  = KEY_W'($urandom_range(NUM_KEYS, 31));
                    end
                endcase
            end
            send_item(it);
        end
    endtask

    // every key struck in turn, so one tick releases all of them together
    task automatic strike_all_keys();
        int k;
        while (tracker.countdown.or() != 0) send_item(tick_item());
        for (k = 0; k < NUM_KEYS; k++) send_item(strike_item(k + 1, random_velocity()));
        repeat (int'(tracker.release_ticks) + 1) send_item(tick_item());
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin : pulse_sink
        int   stall;
        t_res got;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = out_idle ? $urandom_range(0, 6) : 0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            got.channel    = res_if.channel;
            got.pulse_us   = res_if.pulse_us;
            got.is_release = res_if.is_release;
            got.last       = res_if.last;
            tracker.check_pulse(got);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int k;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        item_if.valid <= 1'b0;
        present('0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // key 0 armed under the reset release time, it expires many ticks later
        send_item(cal_item(0, 90, 90, 1000, 2000, 0, 30, 150, 90));   // equal angle limits
        send_item(strike_item(1, 0));
        write_release_ticks('0);

        send_item(cal_item(1, 0, 180, 2000, 1000, 10, 20, 160, 90));  // crossed pulse limits
        send_item(cal_item(2, 0, 180, 500, 2500, 90, 0, 180, 180));   // clamps high
        send_item(cal_item(15, 180, 0, 0, 4095, -90, 180, 0, 0));     // falling angle map
        send_item(cal_item(16, 255, 255, 4095, 4095, -128, 255, 255, 255));
        send_item(cal_item(31, 0, 0, 0, 0, 127, 0, 0, 0));
        send_item(strike_item(0, 127));
        send_item(strike_item(17, 64));
        send_item(strike_item(31, 127));
        send_item(strike_item(1, 127));                                // busy key
        send_item(strike_item(2, 0));
        send_item(strike_item(3, 127));
        send_item(strike_item(16, 64));
        send_item(strike_item(3, 99));                                 // busy key
        begin
            t_item odd;
            odd      = random_fill();
            odd.mode = MODE_UNUSED;
            send_item(odd);
        end
        send_item(cal_item(2, 10, 170, 600, 2400, -90, 40, 140, 45)); // load on busy key
        send_item(tick_item());
        send_item(tick_item());
        send_item(strike_item(3, 127));
        send_item(tick_item());
        send_item(tick_item());

        for (k = 0; k < NUM_KEYS; k++) send_item(random_cal(k));

        write_release_ticks(TICK_W'($urandom_range(1, 7)));
        hold_off_cycles = LONG_HOLD;
        run_random(90, 45, 35);

        write_release_ticks(TICK_W'(5));
        strike_all_keys();

        // back to back on both sides
        write_release_ticks('0);
        in_idle  = 1'b0;
        out_idle = 1'b0;
        run_random(60, 45, 35);
        in_idle  = 1'b1;
        out_idle = 1'b1;

        write_release_ticks(TICK_W'(40));
        run_random(70, 25, 65);

        write_release_ticks(TICK_MAX);
        run_random(30, 50, 40);

        drain_results();
        if (tracker.errors == 0 && tracker.pending_pulses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hdl/sks_pkg.sv
hdl/sks_if.sv
hdl/sks_divider.sv
hdl/sks_datapath.sv
hdl/sks_ctrl.sv
hdl/servo_key_striker_with_release_timer.sv
verif/tb_servo_key_striker_with_release_timer.sv
